// File: design/assert_macros.svh
// Assertion macros shared by the transport stream parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/tsphp_pkg.sv
// Types and constants of the transport stream packet header parser
`timescale 1ns / 1ps
`default_nettype none

package tsphp_pkg;

    // Record kinds carried on the result tuser
    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_SYNC_ERR = 2'd2
    } kind_t;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] TS_LEN       = 8'd188;
    localparam logic [7:0] TC_LEN       = 8'd192;
    localparam logic [7:0] TC_PREFIX    = 8'd4;
    localparam logic [7:0] LAST_IDX     = 8'd187;
    localparam logic [7:0] PCR_MIN_LEN  = 8'd7;

    // Transport header byte positions
    localparam logic [7:0] T_SYNC       = 8'd0;
    localparam logic [7:0] T_PID_HI     = 8'd1;
    localparam logic [7:0] T_PID_LO     = 8'd2;
    localparam logic [7:0] T_CTRL       = 8'd3;
    localparam logic [7:0] T_ADAPT_LEN  = 8'd4;
    localparam logic [7:0] T_ADAPT_FLG  = 8'd5;
    localparam logic [7:0] T_PCR_FIRST  = 8'd6;
    localparam logic [7:0] T_PCR_LAST8  = 8'd9;
    localparam logic [7:0] T_PCR_BIT    = 8'd10;

    // Control byte and adaptation flag bits
    localparam int CTRL_ADAPT_BIT   = 5;
    localparam int CTRL_PAYLOAD_BIT = 4;
    localparam int ADAPT_PCR_BIT    = 4;

    localparam int PCR_W   = 33;
    localparam int TDATA_W = 72;

endpackage

`default_nettype wire

// File: design/ts_packet_header_parser_unit.sv
// Transport stream packet header parser: byte stream in, header and payload records out
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Takes one transport stream byte per transfer, one in every cycle as long as
// the result side keeps up; a record that waits in the output register while
// m_tready is low holds the input until it is taken. Each byte is decoded in
// one pass against the packet state and its record (if any) is valid in the
// cycle after the byte is taken. Packets are 188 bytes, or 192 bytes with a
// 4-byte timecode prefix that is dropped when timecode_mode is set (write it
// only while the stream is idle). A bad sync byte gives one sync error record
// and the rest of that packet is dropped. A good packet gives one header record
// on its last header byte, then one record per payload byte with tlast on the
// final byte of the packet. The PCR base is reported only when the adaptation
// field is at least 7 bytes long and its PCR flag is set.
module ts_packet_header_parser_unit
    import tsphp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration: timecode_mode
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] in_byte
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [12:0] pid, [13] unit_start, [14] transport_error, [15] priority_res,
    // [17:16] scrambling, [21:18] continuity, [22] has_payload, [23] pcr_valid,
    // [56:24] pcr_base, [64:57] data_byte, [71:65] zero
    output logic [TDATA_W-1:0]        m_tdata,
    output logic [1:0]                m_tuser,   // [1:0] kind
    output logic                      m_tlast    // last
);

    // Packet state
    logic              timecode_mode_reg;
    logic [7:0]        byte_pos_reg,    byte_pos_next;
    logic [12:0]       pid_reg,         pid_next;
    logic [2:0]        flag_bits_reg,   flag_bits_next;
    logic [7:0]        ctrl_byte_reg,   ctrl_byte_next;
    logic [7:0]        adapt_len_reg,   adapt_len_next;
    logic [7:0]        adapt_flags_reg, adapt_flags_next;
    logic [PCR_W-1:0]  pcr_shift_reg,   pcr_shift_next;
    logic              skip_packet_reg, skip_packet_next;

    // Output register
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg,  m_tdata_next;
    logic [1:0]          m_tuser_reg,  m_tuser_next;
    logic                m_tlast_reg,  m_tlast_next;

    logic              s_accept;
    logic              emit;
    logic [7:0]        plen;
    logic [7:0]        off;
    logic [8:0]        pos_inc;
    logic              in_range;
    logic [7:0]        t_idx;
    logic [8:0]        adapt_end;
    logic [8:0]        adapt_tail;
    logic [7:0]        hdr_end;
    logic              has_payload;
    logic              pcr_valid;
    logic [PCR_W-1:0]  pcr_out;
    logic [TDATA_W-1:0] hdr_fields;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Packet geometry for the current mode
    assign plen     = timecode_mode_reg ? TC_LEN : TS_LEN;
    assign off      = timecode_mode_reg ? TC_PREFIX : 8'd0;
    assign pos_inc  = {1'b0, byte_pos_reg} + 9'd1;
    assign in_range = (byte_pos_reg >= off) && (byte_pos_reg < plen);
    assign t_idx    = byte_pos_reg - off;

    // Update the packet state from one byte
    always_comb begin
        byte_pos_next    = (pos_inc >= {1'b0, plen}) ? 8'd0 : pos_inc[7:0];
        pid_next         = pid_reg;
        flag_bits_next   = flag_bits_reg;
        ctrl_byte_next   = ctrl_byte_reg;
        adapt_len_next   = adapt_len_reg;
        adapt_flags_next = adapt_flags_reg;
        pcr_shift_next   = pcr_shift_reg;
        skip_packet_next = skip_packet_reg;

        if (in_range) begin
            if (t_idx == T_SYNC) begin
                skip_packet_next = (s_tdata != SYNC_BYTE);
            end else if (!skip_packet_reg) begin
                // Capture header fields
                if (t_idx == T_PID_HI) begin
                    flag_bits_next = s_tdata[7:5];
                    pid_next       = {s_tdata[4:0], pid_reg[7:0]};
                end else if (t_idx == T_PID_LO) begin
                    pid_next = {pid_reg[12:8], s_tdata};
                end else if (t_idx == T_CTRL) begin
                    ctrl_byte_next   = s_tdata;
                    adapt_len_next   = '0;
                    adapt_flags_next = '0;
                    pcr_shift_next   = '0;
                end else if (ctrl_byte_reg[CTRL_ADAPT_BIT] && t_idx <= T_PCR_BIT) begin
                    if (t_idx == T_ADAPT_LEN) begin
                        adapt_len_next = s_tdata;
                    end else if (t_idx == T_ADAPT_FLG) begin
                        adapt_flags_next = s_tdata;
                    end else if (t_idx inside {[T_PCR_FIRST:T_PCR_LAST8]}) begin
                        pcr_shift_next = {pcr_shift_reg[PCR_W-9:0], s_tdata};
                    end else begin
                        pcr_shift_next = {pcr_shift_reg[PCR_W-2:0], s_tdata[7]};
                    end
                end
            end
        end
    end

    // Header end and payload presence from the updated header state
    assign adapt_end  = {1'b0, adapt_len_next} + 9'd4;
    assign adapt_tail = {1'b0, adapt_len_next} + 9'd5;
    assign hdr_end    = !ctrl_byte_next[CTRL_ADAPT_BIT] ? T_CTRL :
                        (adapt_end > {1'b0, LAST_IDX}) ? LAST_IDX : adapt_end[7:0];
    assign has_payload = ctrl_byte_next[CTRL_PAYLOAD_BIT] &&
                         (!ctrl_byte_next[CTRL_ADAPT_BIT] || adapt_tail < {1'b0, TS_LEN});
    assign pcr_valid  = ctrl_byte_next[CTRL_ADAPT_BIT] && (adapt_len_next >= PCR_MIN_LEN) &&
                        adapt_flags_next[ADAPT_PCR_BIT];
    assign pcr_out    = pcr_valid ? pcr_shift_next : '0;

    // Pack the header fields shared by header and payload records
    always_comb begin
        hdr_fields        = '0;
        hdr_fields[12:0]  = pid_next;
        hdr_fields[13]    = flag_bits_next[1];
        hdr_fields[14]    = flag_bits_next[2];
        hdr_fields[15]    = flag_bits_next[0];
        hdr_fields[17:16] = ctrl_byte_next[7:6];
        hdr_fields[21:18] = ctrl_byte_next[3:0];
        hdr_fields[22]    = has_payload;
        hdr_fields[23]    = pcr_valid;
        hdr_fields[56:24] = pcr_out;
    end

    // Build the record for one byte: sync error, header or payload
    always_comb begin
        emit         = 1'b0;
        m_tdata_next = '0;
        m_tuser_next = KIND_HEADER;
        m_tlast_next = 1'b0;

        if (in_range) begin
            if (t_idx == T_SYNC) begin
                if (s_tdata != SYNC_BYTE) begin
                    emit         = 1'b1;
                    m_tuser_next = KIND_SYNC_ERR;
                end
            end else if (!skip_packet_reg && t_idx >= T_CTRL) begin
                if (t_idx == hdr_end) begin
                    emit         = 1'b1;
                    m_tdata_next = hdr_fields;
                    m_tuser_next = KIND_HEADER;
                end else if (t_idx > hdr_end) begin
                    emit         = has_payload;
                    m_tdata_next = hdr_fields;
                    m_tdata_next[64:57] = s_tdata;
                    m_tuser_next = KIND_PAYLOAD;
                    m_tlast_next = (t_idx == LAST_IDX);
                end
            end
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timecode_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            timecode_mode_reg <= cfg_wr_data;
        end
    end

    // Advance packet state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg    <= '0;
            pid_reg         <= '0;
            flag_bits_reg   <= '0;
            ctrl_byte_reg   <= '0;
            adapt_len_reg   <= '0;
            adapt_flags_reg <= '0;
            pcr_shift_reg   <= '0;
            skip_packet_reg <= 1'b0;
        end else if (s_accept) begin
            byte_pos_reg    <= byte_pos_next;
            pid_reg         <= pid_next;
            flag_bits_reg   <= flag_bits_next;
            ctrl_byte_reg   <= ctrl_byte_next;
            adapt_len_reg   <= adapt_len_next;
            adapt_flags_reg <= adapt_flags_next;
            pcr_shift_reg   <= pcr_shift_next;
            skip_packet_reg <= skip_packet_next;
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_ALWAYS(a_pos_bound, byte_pos_reg < TC_LEN, "byte position beyond packet")
    `ASSERT_IMPLY(a_last_payload, m_tvalid && m_tlast, m_tuser == KIND_PAYLOAD,
                  "tlast on non-payload record")
    `ASSERT_IMPLY(a_err_clean, m_tvalid && m_tuser == KIND_SYNC_ERR,
                  m_tdata == '0 && !m_tlast, "sync error record carries fields")
    `ASSERT_IMPLY(a_pcr_zero, m_tvalid && !m_tdata[23], m_tdata[56:24] == '0,
                  "PCR base without PCR valid")
    `ASSERT_IMPLY(a_payload_flag, m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[22],
                  "payload record without payload")

endmodule

`default_nettype wire

// File: tb/ts_packet_header_parser_unit_tb.sv
// Self-checking testbench for the transport stream packet header parser
`timescale 1ns / 1ps

module ts_packet_header_parser_unit_tb
    import tsphp_pkg::*;
;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int ITEM_BUDGET = 1850;

    // One decoded record, as the result stream carries it
    typedef struct packed {
        kind_t       kind;
        logic [12:0] pid;
        logic        unit_start;
        logic        transport_error;
        logic        priority_res;
        logic [1:0]  scrambling;
        logic [3:0]  continuity;
        logic        has_payload;
        logic        pcr_valid;
        logic [32:0] pcr_base;
        logic [7:0]  data_byte;
        logic        last;
    } ts_rec_t;

    // One packet to send: mode, header bytes t=0..10, optional cut-off point
    typedef struct packed {
        logic            mode;
        logic [7:0]      cut;
        logic [10:0][7:0] hdr;
        logic            typed;
        ts_rec_t         rec;
    } ts_pkt_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'h00;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    // Shadow copy of the parser state
    logic [7:0]  pos_q;
    logic [12:0] pid_q;
    logic [2:0]  flags_q;
    logic [7:0]  ctrl_q;
    logic [7:0]  alen_q;
    logic [7:0]  aflags_q;
    logic [32:0] pcr_q;
    logic        skip_q;
    logic        tc_mode;

    ts_rec_t rec_due_q[$];
    ts_pkt_t pkt_plan_q[$];
    ts_rec_t typed_rec;
    bit      typed_due;
    bit      calm;

    int cycle_cnt, fail_cnt, rec_cnt, hdr_cnt, pay_cnt, sync_err_cnt;
    int byte_cnt, used_cnt, pkt_cnt, mode_writes;

    ts_packet_header_parser_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d records outstanding",
                     cycle_cnt, rec_due_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result side at random, except during calm stretches
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 33);
    end

    // Advance the shadow state by one stream byte and work out its record
    function automatic void decode_ts_byte(input logic [7:0] b, output bit got,
                                           output bit used, output ts_rec_t rec);
        int  plen, off, pos, t, he, hlen;
        bit  pv;
        plen = tc_mode ? int'(TC_LEN) : int'(TS_LEN);
        off  = tc_mode ? int'(TC_PREFIX) : 0;
        pos  = int'(pos_q);
        got  = 1'b0;
        used = 1'b0;
        rec  = '0;
        pos_q = (pos + 1 >= plen) ? 8'd0 : 8'(pos + 1);
        // timecode prefix and positions past the packet end are dropped
        if (pos < off || pos >= plen)
            return;
        t = pos - off;
        used = 1'b1;
        if (t == int'(T_SYNC)) begin
            skip_q = (b != SYNC_BYTE);
            if (skip_q) begin
                rec.kind = KIND_SYNC_ERR;
                got = 1'b1;
            end
            return;
        end
        if (skip_q) begin
            used = 1'b0;
            return;
        end
        if (t == int'(T_PID_HI)) begin
            flags_q      = b[7:5];
            pid_q[12:8]  = b[4:0];
        end else if (t == int'(T_PID_LO)) begin
            pid_q[7:0] = b;
        end else if (t == int'(T_CTRL)) begin
            ctrl_q   = b;
            alen_q   = '0;
            aflags_q = '0;
            pcr_q    = '0;
        end else if (ctrl_q[CTRL_ADAPT_BIT] && t <= int'(T_PCR_BIT)) begin
            if (t == int'(T_ADAPT_LEN))
                alen_q = b;
            else if (t == int'(T_ADAPT_FLG))
                aflags_q = b;
            else if (t <= int'(T_PCR_LAST8))
                pcr_q = {pcr_q[24:0], b};
            else
                pcr_q = {pcr_q[31:0], b[7]};
        end
        if (t < int'(T_CTRL))
            return;
        // header ends at the last adaptation byte, clamped to the packet end
        he = ctrl_q[CTRL_ADAPT_BIT] ? int'(T_ADAPT_LEN) + int'(alen_q) : int'(T_CTRL);
        if (he > int'(LAST_IDX))
            he = int'(LAST_IDX);
        if (t < he)
            return;
        hlen = int'(T_ADAPT_LEN) + (ctrl_q[CTRL_ADAPT_BIT] ? 1 + int'(alen_q) : 0);
        pv = ctrl_q[CTRL_ADAPT_BIT] && alen_q >= PCR_MIN_LEN && aflags_q[ADAPT_PCR_BIT];
        rec.pid             = pid_q;
        rec.transport_error = flags_q[2];
        rec.unit_start      = flags_q[1];
        rec.priority_res    = flags_q[0];
        rec.scrambling      = ctrl_q[7:6];
        rec.continuity      = ctrl_q[3:0];
        rec.has_payload     = ctrl_q[CTRL_PAYLOAD_BIT] && hlen < int'(TS_LEN);
        rec.pcr_valid       = pv;
        rec.pcr_base        = pv ? pcr_q : '0;
        if (t == he) begin
            rec.kind = KIND_HEADER;
            got = 1'b1;
            return;
        end
        rec.kind      = KIND_PAYLOAD;
        rec.data_byte = b;
        rec.last      = (t == int'(LAST_IDX));
        got  = rec.has_payload;
        used = rec.has_payload;
    endfunction

    function automatic string rec_diff(input ts_rec_t e, input ts_rec_t a);
        string d;
        d = "";
        if (a.kind != e.kind)
            d = {d, $sformatf(" kind=%0d/%0d", e.kind, a.kind)};
        if (a.pid != e.pid)
            d = {d, $sformatf(" pid=%h/%h", e.pid, a.pid)};
        if (a.unit_start != e.unit_start)
            d = {d, $sformatf(" pusi=%b/%b", e.unit_start, a.unit_start)};
        if (a.transport_error != e.transport_error)
            d = {d, $sformatf(" tei=%b/%b", e.transport_error, a.transport_error)};
        if (a.priority_res != e.priority_res)
            d = {d, $sformatf(" prio=%b/%b", e.priority_res, a.priority_res)};
        if (a.scrambling != e.scrambling)
            d = {d, $sformatf(" scr=%0d/%0d", e.scrambling, a.scrambling)};
        if (a.continuity != e.continuity)
            d = {d, $sformatf(" cc=%0d/%0d", e.continuity, a.continuity)};
        if (a.has_payload != e.has_payload)
            d = {d, $sformatf(" has_pl=%b/%b", e.has_payload, a.has_payload)};
        if (a.pcr_valid != e.pcr_valid)
            d = {d, $sformatf(" pcr_v=%b/%b", e.pcr_valid, a.pcr_valid)};
        if (a.pcr_base != e.pcr_base)
            d = {d, $sformatf(" pcr=%h/%h", e.pcr_base, a.pcr_base)};
        if (a.data_byte != e.data_byte)
            d = {d, $sformatf(" data=%h/%h", e.data_byte, a.data_byte)};
        if (a.last != e.last)
            d = {d, $sformatf(" last=%b/%b", e.last, a.last)};
        return d;
    endfunction

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    // Compare every result transfer against the oldest pending record
    always @(posedge aclk) begin : rec_check
        ts_rec_t seen;
        string   d;
        if (aresetn && m_tvalid && m_tready) begin
            seen.kind            = kind_t'(m_tuser);
            seen.pid             = m_tdata[12:0];
            seen.unit_start      = m_tdata[13];
            seen.transport_error = m_tdata[14];
            seen.priority_res    = m_tdata[15];
            seen.scrambling      = m_tdata[17:16];
            seen.continuity      = m_tdata[21:18];
            seen.has_payload     = m_tdata[22];
            seen.pcr_valid       = m_tdata[23];
            seen.pcr_base        = m_tdata[56:24];
            seen.data_byte       = m_tdata[64:57];
            seen.last            = m_tlast;
            if (rec_due_q.size() == 0) begin
                note_fail($sformatf("record %0d arrived with none pending (kind %0d)",
                                    rec_cnt, m_tuser));
            end else begin
                d = rec_diff(rec_due_q.pop_front(), seen);
                if (m_tdata[TDATA_W-1:65] != '0)
                    d = {d, " nonzero padding"};
                if (d != "")
                    note_fail($sformatf("record %0d expected/actual:%s", rec_cnt, d));
            end
            rec_cnt++;
            case (seen.kind)
                KIND_HEADER:   hdr_cnt++;
                KIND_PAYLOAD:  pay_cnt++;
                default:       sync_err_cnt++;
            endcase
        end
    end

    // Hold one byte on the input until it is taken, then predict its record
    task automatic send_byte(input logic [7:0] b);
        ts_rec_t r;
        bit      got, used;
        while (!calm && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_ts_byte(b, got, used, r);
        byte_cnt++;
        if (used)
            used_cnt++;
        if (got) begin
            rec_due_q.insert(rec_due_q.size(), typed_due ? typed_rec : r);
            typed_due = 1'b0;
        end
    endtask

    // Drop valid and wait until every record is out and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (rec_due_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input bit m);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        tc_mode = m;
        cfg_wr_en <= 1'b0;
        mode_writes++;
    endtask

    // Send one packet from the current position to its end or to its cut-off
    task automatic run_packet(input ts_pkt_t p);
        int plen, off, stop, t;
        if (p.mode != tc_mode)
            write_mode(p.mode);
        plen = tc_mode ? int'(TC_LEN) : int'(TS_LEN);
        off  = tc_mode ? int'(TC_PREFIX) : 0;
        // a position left over from the longer packet size wraps on its own
        if (int'(pos_q) >= plen)
            send_byte(8'($urandom));
        stop = (p.cut != 0) ? int'(p.cut) : plen;
        typed_due = p.typed;
        typed_rec = p.rec;
        for (int q = int'(pos_q); q < stop; q++) begin
            t = q - off;
            send_byte((q >= off && t <= int'(T_PCR_BIT)) ? p.hdr[t] : 8'($urandom));
        end
        typed_due = 1'b0;
        pkt_cnt++;
    endtask

    function automatic void plan(input bit mode, input int cut, input logic [7:0] s, b1, b2,
                                 c, al, af, input logic [39:0] pcrb, input bit typed,
                                 input ts_rec_t rec);
        ts_pkt_t p;
        p = '0;
        p.mode   = mode;
        p.cut    = 8'(cut);
        p.hdr[0] = s;
        p.hdr[1] = b1;
        p.hdr[2] = b2;
        p.hdr[3] = c;
        p.hdr[4] = al;
        p.hdr[5] = af;
        for (int k = 0; k < 5; k++)
            p.hdr[int'(T_PCR_FIRST) + k] = pcrb[39 - 8 * k -: 8];
        p.typed = typed;
        p.rec   = rec;
        pkt_plan_q.insert(pkt_plan_q.size(), p);
    endfunction

    // Header record of a packet with a short header
    function automatic ts_rec_t hdr_rec(input logic [12:0] pid, input logic [2:0] flg,
                                        input logic [7:0] ctrl, input bit pv,
                                        input logic [32:0] pcr);
        ts_rec_t r;
        r = '0;
        r.kind            = KIND_HEADER;
        r.pid             = pid;
        r.transport_error = flg[2];
        r.unit_start      = flg[1];
        r.priority_res    = flg[0];
        r.scrambling      = ctrl[7:6];
        r.continuity      = ctrl[3:0];
        r.has_payload     = ctrl[CTRL_PAYLOAD_BIT];
        r.pcr_valid       = pv;
        r.pcr_base        = pcr;
        return r;
    endfunction

    // Mostly well-formed packets with random content, some bad sync and noise
    task automatic run_random();
        ts_pkt_t p;
        int      n, sel, r;
        n = 0;
        while (byte_cnt + int'(TS_LEN) / 2 < ITEM_BUDGET) begin
            p = '0;
            p.mode = ($urandom_range(3) == 0) ? !tc_mode : tc_mode;
            for (int k = 0; k < 11; k++)
                p.hdr[k] = 8'($urandom);
            sel = $urandom_range(99);
            if (sel < 80) begin
                p.hdr[0] = SYNC_BYTE;
                r = $urandom_range(9);
                if (r < 5)
                    p.hdr[4] = 8'($urandom_range(7, 30));
                else if (r < 7)
                    p.hdr[4] = 8'($urandom_range(0, 6));
                else if (r == 7)
                    p.hdr[4] = 8'($urandom_range(180, 187));
                else if (r == 8)
                    p.hdr[4] = 8'($urandom_range(188, 255));
                if ($urandom_range(9) < 7)
                    p.hdr[5][ADAPT_PCR_BIT] = 1'b1;
            end else if (sel < 90 && p.hdr[0] == SYNC_BYTE) begin
                p.hdr[0] = p.hdr[0] ^ 8'h01;
            end
            if ($urandom_range(11) == 0)
                p.cut = 8'($urandom_range(1, (p.mode ? int'(TC_LEN) : int'(TS_LEN)) - 1));
            // keep the first packet free of idle cycles on both sides
            calm = (n == 0);
            run_packet(p);
            n++;
        end
        calm = 1'b0;
    endtask

    initial begin
        ts_rec_t err_rec;
        pos_q = '0; pid_q = '0; flags_q = '0; ctrl_q = '0;
        alen_q = '0; aflags_q = '0; pcr_q = '0; skip_q = 1'b0; tc_mode = 1'b0;
        err_rec = '0;
        err_rec.kind = KIND_SYNC_ERR;

        // mode, cut, sync, pid hi, pid lo, ctrl, adapt len, adapt flags, PCR bytes
        plan(0, 0, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 40'h0, 1, err_rec);
        plan(0, 0, 8'h47, 8'hFF, 8'hFF, 8'hDF, 8'h00, 8'h00, 40'h0, 1,
             hdr_rec(13'h1FFF, 3'b111, 8'hDF, 1'b0, 33'h0));
        // largest PCR base with the shortest adaptation field that carries one
        plan(0, 0, 8'h47, 8'h01, 8'h00, 8'h30, 8'h07, 8'h10, 40'hFF_FFFF_FFFF, 1,
             hdr_rec(13'h0100, 3'b000, 8'h30, 1'b1, 33'h1_FFFF_FFFF));
        // adaptation field one byte too short for a PCR
        plan(0, 0, 8'h47, 8'h1F, 8'hFF, 8'h30, 8'h06, 8'hFF, {$urandom, 8'($urandom)}, 0, '0);
        // header fills the packet exactly: record on the last byte, no payload
        plan(0, 0, 8'h47, 8'h40, 8'h11, 8'h30, 8'd183, 8'h10, {$urandom, 8'($urandom)}, 0, '0);
        // one payload byte left, marked last
        plan(0, 0, 8'h47, 8'hA0, 8'h22, 8'h3A, 8'd182, 8'h10, {$urandom, 8'($urandom)}, 0, '0);
        // switch modes mid-packet from a position beyond the short size
        plan(1, 190, 8'h47, 8'h2A, 8'h55, 8'h1B, 8'h00, 8'h00, 40'h0, 0, '0);
        plan(0, 0, 8'h47, 8'h33, 8'h66, 8'hB4, 8'h00, 8'h00, 40'h0, 0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_mode(1'b0);
        while (pkt_plan_q.size() != 0)
            run_packet(pkt_plan_q.pop_front());
        run_random();
        settle();

        $display("Sent %0d packets, %0d bytes (%0d decoded), %0d timecode mode writes",
                 pkt_cnt, byte_cnt, used_cnt, mode_writes);
        $display("Checked %0d records: %0d header, %0d payload, %0d sync error; %0d failures",
                 rec_cnt, hdr_cnt, pay_cnt, sync_err_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
